[sv/assert_macros.svh]
// Assertion macros shared by the range flow table RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, switched off while reset is held.
`define RFT_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that also holds through reset.
`define RFT_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[sv/rft_pkg.sv]
// Package for the range flow table: word types, codes and controller links.
`timescale 1ns / 1ps

package rft_pkg;

    // Default configuration
    localparam int DEF_TABLE_DEPTH = 16;
    localparam int DEF_COUNT_WIDTH = 16;

    // Field widths
    localparam int FUNC_W  = 2;
    localparam int ADDR_W  = 16;
    localparam int INDEX_W = 4;
    localparam int KIND_W  = 3;
    localparam int HITS_W  = 5;
    localparam int QUERY_W = 16;
    localparam int PKTS_W  = 16;

    localparam logic [HITS_W-1:0]  HITS_MAX  = '1;
    localparam logic [QUERY_W-1:0] QUERY_MAX = '1;

    // Function codes
    localparam logic [FUNC_W-1:0] FUNC_LOOKUP = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_ADD    = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_READ   = 2'd2;
    localparam logic [FUNC_W-1:0] FUNC_NONE   = 2'd3;

    // Result kinds
    localparam logic [KIND_W-1:0] KIND_MATCH = 3'd0;
    localparam logic [KIND_W-1:0] KIND_QUERY = 3'd1;
    localparam logic [KIND_W-1:0] KIND_ADDED = 3'd2;
    localparam logic [KIND_W-1:0] KIND_FULL  = 3'd3;
    localparam logic [KIND_W-1:0] KIND_READ  = 3'd4;

    typedef struct packed {
        logic [FUNC_W-1:0]  func;
        logic [ADDR_W-1:0]  addr_low;
        logic [ADDR_W-1:0]  addr_high;
        logic [INDEX_W-1:0] entry_index;
    } t_in_word;

    typedef struct packed {
        logic [KIND_W-1:0]  result_kind;
        logic [HITS_W-1:0]  hits;
        logic [QUERY_W-1:0] queries_sent;
        logic               entry_valid;
        logic [ADDR_W-1:0]  entry_low;
        logic [ADDR_W-1:0]  entry_high;
        logic [PKTS_W-1:0]  entry_packets;
        logic               entry_drops;
    } t_out_word;

    // Controller to datapath
    typedef struct packed {
        logic load_item;
        logic scan_rd;
        logic entry_rd;
        logic out_load;
    } t_dp_cmd;

    // Datapath to controller
    typedef struct packed {
        logic table_empty;
        logic scan_last;
        logic out_free;
    } t_dp_status;

endpackage

[sv/rft_ctrl.sv]
// Sequencer of the range flow table: takes words in and steps scans and reads.
`timescale 1ns / 1ps

module rft_ctrl (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    input  logic [rft_pkg::FUNC_W-1:0] i_func,
    input  rft_pkg::t_dp_status        i_status,
    output logic                       o_in_stall,
    output rft_pkg::t_dp_cmd           o_cmd
);
    import rft_pkg::*;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_SCAN  = 3'd1;
    localparam logic [2:0] S_FLUSH = 3'd2;
    localparam logic [2:0] S_READ  = 3'd3;
    localparam logic [2:0] S_DONE  = 3'd4;

    logic [2:0] r_state;
    logic [2:0] n_state;
    logic       in_accept;

    assign o_in_stall = (r_state != S_IDLE);
    assign in_accept  = i_in_valid && (r_state == S_IDLE);

    // Next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (in_accept) begin
                    o_cmd.load_item = 1'b1;
                    unique case (i_func)
                        FUNC_LOOKUP: n_state = i_status.table_empty ? S_DONE : S_SCAN;
                        FUNC_ADD:    n_state = S_DONE;
                        FUNC_READ:   n_state = S_READ;
                        default:     n_state = S_IDLE;
                    endcase
                end
            end
            S_SCAN: begin
                o_cmd.scan_rd = 1'b1;
                if (i_status.scan_last) begin
                    n_state = S_FLUSH;
                end
            end
            S_FLUSH: begin
                n_state = S_DONE;
            end
            S_READ: begin
                o_cmd.entry_rd = 1'b1;
                n_state        = S_DONE;
            end
            S_DONE: begin
                if (i_status.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

[sv/rft_datapath.sv]
// Datapath of the range flow table: entry memory, range compare, counters, output word.
`timescale 1ns / 1ps

module rft_datapath #(
    parameter int TABLE_DEPTH = rft_pkg::DEF_TABLE_DEPTH,
    parameter int COUNT_WIDTH = rft_pkg::DEF_COUNT_WIDTH
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  rft_pkg::t_in_word    i_in,
    input  rft_pkg::t_dp_cmd     i_cmd,
    input  logic                 i_out_stall,
    output rft_pkg::t_dp_status  o_status,
    output logic                 o_out_valid,
    output rft_pkg::t_out_word   o_out
);
    import rft_pkg::*;

    localparam int AW   = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int FW   = $clog2(TABLE_DEPTH + 1);
    localparam int CMPW = (FW > INDEX_W) ? FW : INDEX_W;
    localparam int MW   = (COUNT_WIDTH > PKTS_W) ? COUNT_WIDTH : PKTS_W;
    localparam logic [FW-1:0] FILL_FULL = FW'(TABLE_DEPTH);

    // Entry memory, one row per rule
    logic [ADDR_W-1:0]      mem_low  [TABLE_DEPTH];
    logic [ADDR_W-1:0]      mem_high [TABLE_DEPTH];
    logic [COUNT_WIDTH-1:0] mem_cnt  [TABLE_DEPTH];
    logic                   mem_drop [TABLE_DEPTH];

    t_in_word               r_item;
    logic [FW-1:0]          r_fill;
    logic [QUERY_W-1:0]     r_query;
    logic [HITS_W-1:0]      r_hits;
    logic [AW-1:0]          r_scan_idx;
    logic                   r_chk;
    logic [AW-1:0]          r_chk_addr;
    logic [ADDR_W-1:0]      r_rd_low;
    logic [ADDR_W-1:0]      r_rd_high;
    logic [COUNT_WIDTH-1:0] r_rd_cnt;
    logic                   r_rd_drop;
    logic                   r_out_valid;
    t_out_word              r_out;

    logic                   table_full;
    logic                   hit;
    logic                   rd_en;
    logic [AW-1:0]          rd_addr;
    logic                   wr_en;
    logic [AW-1:0]          wr_addr;
    logic [ADDR_W-1:0]      wr_low;
    logic [ADDR_W-1:0]      wr_high;
    logic [COUNT_WIDTH-1:0] wr_cnt;
    logic                   wr_drop;
    logic                   add_commit;
    logic [CMPW-1:0]        idx_cmp;
    logic                   entry_ok;
    logic [MW-1:0]          cnt_ext;
    logic [QUERY_W-1:0]     n_query;
    t_out_word              n_out;

    assign table_full = (r_fill == FILL_FULL);
    assign idx_cmp    = CMPW'(r_item.entry_index);
    assign entry_ok   = (idx_cmp < CMPW'(r_fill));

    // Status to the sequencer
    assign o_status.table_empty = (r_fill == '0);
    assign o_status.scan_last   = (FW'(r_scan_idx) == (r_fill - FW'(1)));
    assign o_status.out_free    = !r_out_valid || !i_out_stall;

    // Range check of the row read in the previous cycle
    assign hit = r_chk && (r_rd_low <= r_item.addr_low) && (r_rd_high >= r_item.addr_high);

    // Read port: scan row or requested entry
    assign rd_en   = i_cmd.scan_rd || i_cmd.entry_rd;
    assign rd_addr = i_cmd.entry_rd ? idx_cmp[AW-1:0] : r_scan_idx;

    // Write port: counter write-back on a hit, new rule on commit of an add
    assign add_commit = i_cmd.out_load && (r_item.func == FUNC_ADD) && !table_full;
    always_comb begin
        wr_en   = hit || add_commit;
        wr_addr = r_chk_addr;
        wr_low  = r_rd_low;
        wr_high = r_rd_high;
        wr_cnt  = (r_rd_cnt == '1) ? r_rd_cnt : r_rd_cnt + COUNT_WIDTH'(1);
        wr_drop = r_rd_drop;
        if (add_commit) begin
            wr_addr = r_fill[AW-1:0];
            wr_low  = r_item.addr_low;
            wr_high = r_item.addr_high;
            wr_cnt  = COUNT_WIDTH'(1);
            wr_drop = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem_low[wr_addr]  <= wr_low;
            mem_high[wr_addr] <= wr_high;
            mem_cnt[wr_addr]  <= wr_cnt;
            mem_drop[wr_addr] <= wr_drop;
        end
        if (rd_en) begin
            r_rd_low  <= mem_low[rd_addr];
            r_rd_high <= mem_high[rd_addr];
            r_rd_cnt  <= mem_cnt[rd_addr];
            r_rd_drop <= mem_drop[rd_addr];
        end
    end

    // Result word
    assign cnt_ext = MW'(r_rd_cnt);
    always_comb begin
        n_query = r_query;
        n_out   = '0;
        case (r_item.func)
            FUNC_LOOKUP: begin
                n_out.hits = r_hits;
                if (r_hits == '0) begin
                    n_out.result_kind = KIND_QUERY;
                    if (r_query != QUERY_MAX) begin
                        n_query = r_query + QUERY_W'(1);
                    end
                end else begin
                    n_out.result_kind = KIND_MATCH;
                end
            end
            FUNC_ADD: begin
                n_out.result_kind = table_full ? KIND_FULL : KIND_ADDED;
            end
            FUNC_READ: begin
                n_out.result_kind = KIND_READ;
                if (entry_ok) begin
                    n_out.entry_valid   = 1'b1;
                    n_out.entry_low     = r_rd_low;
                    n_out.entry_high    = r_rd_high;
                    n_out.entry_packets = (cnt_ext > MW'(17'h0FFFF)) ? '1
                                                                     : cnt_ext[PKTS_W-1:0];
                    n_out.entry_drops   = r_rd_drop;
                end
            end
            default: n_out.result_kind = KIND_MATCH;
        endcase
        n_out.queries_sent = n_query;
    end

    // Item latch, scan pointer and hit tally
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_item) begin
            r_item     <= i_in;
            r_hits     <= '0;
            r_scan_idx <= '0;
        end else begin
            if (i_cmd.scan_rd) begin
                r_scan_idx <= r_scan_idx + AW'(1);
            end
            if (hit && (r_hits != HITS_MAX)) begin
                r_hits <= r_hits + HITS_W'(1);
            end
        end
        if (i_cmd.scan_rd) begin
            r_chk_addr <= r_scan_idx;
        end
        if (i_cmd.out_load) begin
            r_out <= n_out;
        end
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill      <= '0;
            r_query     <= '0;
            r_chk       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_chk <= i_cmd.scan_rd;
            if (i_cmd.out_load) begin
                r_query     <= n_query;
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            if (add_commit) begin
                r_fill <= r_fill + FW'(1);
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule

[sv/range_flow_table_unit.sv]
// Top level of the range flow table: sequencer, datapath and checks.
//
// Input words (lookup, add rule, read entry) arrive on i_in with i_in_valid;
// the block holds o_in_stall high while it works on a word. Each word except
// the unused function code gives one result word on o_out, held in an output
// register with o_out_valid until a cycle with i_out_stall low takes it.
// Steps from acceptance until the result stands in the output register:
//   lookup: scan of every rule, flush, then load (straight to the load when
//   the table is empty), add rule: load, read entry: row read, then load.
// The next word can be taken in the cycle after the load; a word with the
// unused code is dropped in the cycle it is taken. A lookup walks the entry
// memory one row per cycle through its single read port, checks the range of
// each row in the following cycle and writes the raised counter back, so its
// cost grows with the fill level of the table.
// A result waiting under stall does not block the next word; only the load
// of a new result waits until the output register is free.
// Synchronous reset empties the table, clears the query count and drops any
// pending result; entry memory keeps its contents but rows beyond the fill
// level are never used.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module range_flow_table_unit #(
    parameter int TABLE_DEPTH = rft_pkg::DEF_TABLE_DEPTH,
    parameter int COUNT_WIDTH = rft_pkg::DEF_COUNT_WIDTH
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  rft_pkg::t_in_word  i_in,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output rft_pkg::t_out_word o_out
);
    import rft_pkg::*;

    t_dp_cmd    cmd;
    t_dp_status status;
    logic       in_accept;

    assign in_accept = i_in_valid && !o_in_stall;

    rft_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_func     (i_in.func),
        .i_status   (status),
        .o_in_stall (o_in_stall),
        .o_cmd      (cmd)
    );

    rft_datapath #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (i_in),
        .i_cmd       (cmd),
        .i_out_stall (i_out_stall),
        .o_status    (status),
        .o_out_valid (o_out_valid),
        .o_out       (o_out)
    );

    // A result is only loaded into a free output register
    `RFT_ASSERT(a_load_free, i_clk, i_rst_n, cmd.out_load |-> status.out_free, "result load while output busy")
    // A word that gives a result keeps the input stalled in the next cycle
    `RFT_ASSERT(a_busy_after_take, i_clk, i_rst_n, (in_accept && (i_in.func != FUNC_NONE)) |=> o_in_stall, "input open while word in flight")
    // No scan of an empty table
    `RFT_ASSERT(a_scan_nonempty, i_clk, i_rst_n, cmd.scan_rd |-> !status.table_empty, "scan of empty table")

endmodule

[tb/testbench.sv]
// Self-checking testbench for the range flow table: stimulus, prediction and result checks.
`timescale 1ns / 1ps

module testbench;
    import rft_pkg::*;

    localparam int          DEPTH      = DEF_TABLE_DEPTH;
    localparam int unsigned PKT_TOP    = 32'((64'd1 << DEF_COUNT_WIDTH) - 64'd1);
    localparam int          ADDR_TOP   = 65535;
    localparam int          RAND_WORDS = 1400;
    localparam int          STUCK_MAX  = 2000;
    localparam int          HOLD_LEN   = 300;

    typedef struct {
        t_in_word w;
        bit       drain;
    } t_pending;

    logic      i_clk = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      in_valid = 1'b0;
    logic      in_stall;
    t_in_word  in_word = '0;
    logic      out_valid;
    logic      out_stall = 1'b0;
    t_out_word out_word;

    // Words waiting to go out, and results the table should give back
    t_pending  words_to_send[$];
    t_out_word results_due[$];

    // Shadow copy of the flow table
    logic [ADDR_W-1:0] rule_lo   [DEPTH];
    logic [ADDR_W-1:0] rule_hi   [DEPTH];
    int unsigned       rule_pkts [DEPTH];
    bit                rule_drop [DEPTH];
    bit                rule_used [DEPTH];
    int                rules_held = 0;
    logic [QUERY_W-1:0] miss_count = '0;

    // Rules as the generator expects them to land
    int gen_lo[$];
    int gen_hi[$];

    int errors = 0;
    int rx_count = 0;
    int hold_left = 0;
    int stuck = 0;
    int cyc = 0;
    int n_match = 0, n_query = 0, n_added = 0, n_full = 0, n_read = 0;

    range_flow_table_unit DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in        (in_word),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out       (out_word)
    );

    always #1 i_clk = ~i_clk;

    // Random gaps, switched off over one long window
    function automatic bit take_break();
        return (cyc < 6000 || cyc >= 10000) && ($urandom_range(99) < 10);
    endfunction

    // Apply one word to the shadow table and return the result it should give
    function automatic t_out_word apply_to_table(t_in_word w);
        t_out_word r;
        int        n;
        int        i;
        r = '0;
        case (w.func)
            FUNC_LOOKUP: begin
                n = 0;
                for (i = 0; i < DEPTH; i++) begin
                    if (rule_used[i] && rule_lo[i] <= w.addr_low &&
                        rule_hi[i] >= w.addr_high) begin
                        if (rule_pkts[i] < PKT_TOP) rule_pkts[i]++;
                        n++;
                    end
                end
                if (n == 0) begin
                    if (miss_count != QUERY_MAX) miss_count++;
                    r.result_kind = KIND_QUERY;
                end else begin
                    r.result_kind = KIND_MATCH;
                end
                r.hits = (n > HITS_MAX) ? HITS_MAX : HITS_W'(n);
            end
            FUNC_ADD: begin
                if (rules_held < DEPTH) begin
                    rule_lo[rules_held]   = w.addr_low;
                    rule_hi[rules_held]   = w.addr_high;
                    rule_pkts[rules_held] = 1;
                    rule_drop[rules_held] = 1'b1;
                    rule_used[rules_held] = 1'b1;
                    rules_held++;
                    r.result_kind = KIND_ADDED;
                end else begin
                    r.result_kind = KIND_FULL;
                end
            end
            default: begin
                r.result_kind = KIND_READ;
                if (w.entry_index < DEPTH && rule_used[w.entry_index]) begin
                    r.entry_valid   = 1'b1;
                    r.entry_low     = rule_lo[w.entry_index];
                    r.entry_high    = rule_hi[w.entry_index];
                    r.entry_packets = (rule_pkts[w.entry_index] > 32'hFFFF) ?
                                      16'hFFFF : PKTS_W'(rule_pkts[w.entry_index]);
                    r.entry_drops   = rule_drop[w.entry_index];
                end
            end
        endcase
        r.queries_sent = miss_count;
        return r;
    endfunction

    task automatic check_field(input string fname, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %0h, got %0h", $time, fname, want, got);
            errors++;
        end
    endtask

    task automatic send_word(input logic [FUNC_W-1:0] f, input int lo, input int hi,
                             input int idx, input bit drain = 1'b0);
        t_pending p;
        p.w.func        = f;
        p.w.addr_low    = ADDR_W'(lo);
        p.w.addr_high   = ADDR_W'(hi);
        p.w.entry_index = INDEX_W'(idx);
        p.drain         = drain;
        words_to_send.insert(words_to_send.size(), p);
        if (f == FUNC_ADD && gen_lo.size() < DEPTH) begin
            gen_lo.insert(gen_lo.size(), lo);
            gen_hi.insert(gen_hi.size(), hi);
        end
    endtask

    // Driver: offers the next pending word, holds it until taken
    always @(posedge i_clk) begin
        t_pending head;
        bit       offer;
        offer = in_valid;
        if (!i_rst_n) begin
            offer = 1'b0;
        end else begin
            if (in_valid && !in_stall) begin
                if (in_word.func != FUNC_NONE) begin
                    results_due.insert(results_due.size(), apply_to_table(in_word));
                end
                offer = 1'b0;
            end
            if (!offer && words_to_send.size() > 0 && !take_break() &&
                !(words_to_send[0].drain && results_due.size() != 0)) begin
                head = words_to_send.pop_front();
                in_word <= head.w;
                offer = 1'b1;
            end
        end
        in_valid <= offer;
    end

    // Monitor: takes results, checks them, and applies back-pressure
    always @(posedge i_clk) begin
        t_out_word want;
        bit        stall_next;
        stall_next = 1'b0;
        if (i_rst_n) begin
            if (out_valid && !out_stall) begin
                if (results_due.size() == 0) begin
                    $display("%0t: result with nothing pending, expected none, got %h",
                             $time, out_word);
                    errors++;
                end else begin
                    want = results_due.pop_front();
                    check_field("result_kind", 32'(want.result_kind),
                                32'(out_word.result_kind));
                    check_field("hits", 32'(want.hits), 32'(out_word.hits));
                    check_field("queries_sent", 32'(want.queries_sent),
                                32'(out_word.queries_sent));
                    check_field("entry_valid", 32'(want.entry_valid),
                                32'(out_word.entry_valid));
                    check_field("entry_low", 32'(want.entry_low), 32'(out_word.entry_low));
                    check_field("entry_high", 32'(want.entry_high), 32'(out_word.entry_high));
                    check_field("entry_packets", 32'(want.entry_packets),
                                32'(out_word.entry_packets));
                    check_field("entry_drops", 32'(want.entry_drops),
                                32'(out_word.entry_drops));
                end
                case (out_word.result_kind)
                    KIND_MATCH: n_match++;
                    KIND_QUERY: n_query++;
                    KIND_ADDED: n_added++;
                    KIND_FULL:  n_full++;
                    default:    n_read++;
                endcase
                rx_count++;
                // long hold-off after the twentieth result so the block backs up into its input
                if (rx_count % 40000 == 20) hold_left = HOLD_LEN;
            end
            if (hold_left > 0) begin
                stall_next = 1'b1;
                hold_left--;
            end else begin
                stall_next = take_break();
            end
        end
        out_stall <= stall_next;
    end

    // Watchdog on cycles with no word moving either way
    always @(posedge i_clk) begin
        cyc <= cyc + 1;
        if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
            stuck <= 0;
        end else begin
            stuck <= stuck + 1;
        end
        if (stuck >= STUCK_MAX) begin
            $display("simulation failed");
            $finish;
        end
    end

    initial begin
        int n;
        int k;
        int lo;
        int hi;
        int r;

        foreach (rule_used[i]) begin
            rule_lo[i]   = '0;
            rule_hi[i]   = '0;
            rule_pkts[i] = 0;
            rule_drop[i] = 1'b0;
            rule_used[i] = 1'b0;
        end

        // Empty table: reads of unused entries, ignored code, misses; then one rule added, hit and read back
        send_word(FUNC_READ, ADDR_TOP, ADDR_TOP, 0);
        send_word(FUNC_READ, 0, 0, 15);
        send_word(FUNC_NONE, 'h1234, 'hABCD, 7);
        send_word(FUNC_LOOKUP, 0, 0, 0);
        send_word(FUNC_LOOKUP, ADDR_TOP, ADDR_TOP, 15);
        send_word(FUNC_ADD, 'h8000, 'h8000, 0);
        send_word(FUNC_LOOKUP, 'h8000, 'h8000, 0);
        send_word(FUNC_LOOKUP, 'h7FFF, 'h8000, 0);
        send_word(FUNC_READ, 0, 0, 0);

        // Read-back after a pause, inverted and full-width rules, multiple hits
        send_word(FUNC_READ, 0, 0, 0, 1'b1);
        send_word(FUNC_LOOKUP, 'h8000, 'h8000, 0);
        send_word(FUNC_READ, 0, 0, 0);
        send_word(FUNC_ADD, ADDR_TOP, 0, 0);
        send_word(FUNC_ADD, 0, ADDR_TOP, 0);
        send_word(FUNC_ADD, 0, 0, 0);
        send_word(FUNC_LOOKUP, 0, 0, 0);
        send_word(FUNC_LOOKUP, ADDR_TOP, ADDR_TOP, 0);
        send_word(FUNC_LOOKUP, 'h9000, 'h0100, 0);
        send_word(FUNC_READ, 0, 0, 1);
        send_word(FUNC_READ, 0, 0, 2);
        send_word(FUNC_READ, 0, 0, 15);
        send_word(FUNC_NONE, 0, 0, 0);

        // Random mix; ignored words do not count
        n = 0;
        while (n < RAND_WORDS) begin
            r = $urandom_range(99);
            if (r < 58) begin
                if (gen_lo.size() > 0 && $urandom_range(1)) begin
                    k  = $urandom_range(gen_lo.size() - 1);
                    lo = gen_lo[k];
                    hi = gen_hi[k];
                    if (lo <= hi) begin
                        send_word(FUNC_LOOKUP, $urandom_range(hi, lo), $urandom_range(hi, lo),
                                  $urandom_range(15), $urandom_range(199) == 0);
                    end else begin
                        send_word(FUNC_LOOKUP, $urandom_range(ADDR_TOP),
                                  $urandom_range(ADDR_TOP), $urandom_range(15));
                    end
                end else begin
                    send_word(FUNC_LOOKUP, $urandom_range(ADDR_TOP), $urandom_range(ADDR_TOP),
                              $urandom_range(15), $urandom_range(199) == 0);
                end
                n++;
            end else if (r < 73) begin
                case ($urandom_range(9))
                    0: begin
                        lo = 0;
                        hi = ADDR_TOP;
                    end
                    1: begin
                        lo = $urandom_range(ADDR_TOP, 1);
                        hi = $urandom_range(lo - 1);
                    end
                    2, 3: begin
                        lo = $urandom_range(ADDR_TOP);
                        hi = lo + $urandom_range((ADDR_TOP - lo > 255) ? 255 : ADDR_TOP - lo);
                    end
                    default: begin
                        lo = $urandom_range(ADDR_TOP);
                        hi = $urandom_range(ADDR_TOP, lo);
                    end
                endcase
                send_word(FUNC_ADD, lo, hi, $urandom_range(15));
                n++;
            end else if (r < 93) begin
                send_word(FUNC_READ, $urandom_range(ADDR_TOP), $urandom_range(ADDR_TOP),
                          $urandom_range(15));
                n++;
            end else begin
                send_word(FUNC_NONE, $urandom_range(ADDR_TOP), $urandom_range(ADDR_TOP),
                          $urandom_range(15));
            end
        end

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (words_to_send.size() != 0 || in_valid || results_due.size() != 0)
            @(posedge i_clk);
        repeat (40) @(posedge i_clk);

        $display("Checked %0d results: %0d matches, %0d queries, %0d rules added,",
                 rx_count, n_match, n_query, n_added);
        $display("%0d adds refused on a full table, %0d entry reads; %0d field errors",
                 n_full, n_read, errors);
        if (errors == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
